FILE: rtl/multi_sender_mailbox_round_robin_defines.svh
// assertion macros shared by the mailbox rtl
// expects clk and arst_n in the scope of each use
`ifndef MULTI_SENDER_MAILBOX_ROUND_ROBIN_DEFINES_SVH
`define MULTI_SENDER_MAILBOX_ROUND_ROBIN_DEFINES_SVH

// same-cycle implication, off while in reset
`define MBX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define MBX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mbx_pkg.sv
// shared types and constants of the round-robin mailbox
// no dependencies
package mbx_pkg;

	localparam int LANES     = 8;
	localparam int LANE_W    = 3;
	localparam int SENDER_W  = 6;
	localparam int MSG_W     = 32;
	localparam int PAYLOAD_W = 32;
	localparam int MASK_W    = 64;
	localparam int ONES_W    = 4;

	typedef enum logic [2:0] {
		ST_ACCEPTED     = 3'd0,
		ST_BUSY         = 3'd1,
		ST_UNREGISTERED = 3'd2,
		ST_DELIVERED    = 3'd3,
		ST_EMPTY        = 3'd4
	} status_t;

	// search token travelling around the ring of cells
	typedef struct packed {
		logic vld;
		logic wrapped;
	} tok_t;

	// per-cell controls driven by the top level
	typedef struct packed {
		logic              set_vld;
		logic [LANE_W-1:0] set_lane;
		logic              cfg_we;
		logic [LANES-1:0]  cfg_bits;
		logic              is_start;
		logic [LANE_W-1:0] start_lo;
	} cell_ctl_t;

	// per-cell status returned to the top level
	typedef struct packed {
		logic [LANES-1:0]  ready;
		logic [LANES-1:0]  mask;
		logic [ONES_W-1:0] ones;
		logic              hit;
		logic              miss_end;
		logic [LANE_W-1:0] hit_lane;
	} cell_sts_t;

endpackage

FILE: rtl/mbx_if.sv
// valid/ready channel interfaces of the mailbox: request, response, config
// depends on mbx_pkg
interface mbx_req_if import mbx_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [SENDER_W-1:0] sender;
	logic [MSG_W-1:0]    message;

	modport source (output valid, kind, sender, message, input ready);
	modport sink (input valid, kind, sender, message, output ready);
endinterface

interface mbx_rsp_if import mbx_pkg::*; ();
	logic                 valid;
	logic                 ready;
	status_t              status;
	logic [SENDER_W-1:0]  slot;
	logic [PAYLOAD_W-1:0] payload;

	modport source (output valid, status, slot, payload, input ready);
	modport sink (input valid, status, slot, payload, output ready);
endinterface

interface mbx_cfg_if import mbx_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] sender_mask;

	modport source (output valid, sender_mask, input ready);
	modport sink (input valid, sender_mask, output ready);
endinterface

FILE: rtl/mbx_cell.sv
// one cell of the mailbox ring: ready and registration bits of eight slots
// depends on mbx_pkg and the defines header
`include "multi_sender_mailbox_round_robin_defines.svh"

module mbx_cell import mbx_pkg::*; #(
	parameter logic [LANES-1:0] MASK_RST = '0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  tok_t      tok_in,
	output tok_t      tok_out,
	output cell_sts_t sts
);

	logic [LANES-1:0] ready_q;
	logic [LANES-1:0] mask_q;
	tok_t             tok_q;
	logic [LANES-1:0] sel;
	logic [LANES-1:0] cand;
	logic [ONES_W-1:0] ones;
	logic [LANE_W-1:0] first;

	// lanes eligible on this visit: start cell is split around the start lane
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (!ctl.is_start) begin
				sel[i] = 1'b1;
			end else if (tok_in.wrapped) begin
				sel[i] = (LANE_W'(i) < ctl.start_lo);
			end else begin
				sel[i] = (LANE_W'(i) >= ctl.start_lo);
			end
		end
		cand = ready_q & sel & {LANES{tok_in.vld}};
	end

	// lowest eligible lane and count of registered lanes
	always_comb begin
		first = '0;
		ones  = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (cand[i]) begin
				first = LANE_W'(i);
			end
		end
		for (int i = 0; i < LANES; i++) begin
			ones = ones + ONES_W'(mask_q[i]);
		end
	end

	always_comb begin
		sts.ready    = ready_q;
		sts.mask     = mask_q;
		sts.ones     = ones;
		sts.hit      = |cand;
		sts.miss_end = tok_in.vld && ctl.is_start && tok_in.wrapped && !(|cand);
		sts.hit_lane = first;
	end

	assign tok_out = tok_q;

	// slot bits and token hand-off to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= '0;
			mask_q  <= MASK_RST;
			tok_q   <= '0;
		end else begin
			if (ctl.set_vld) begin
				ready_q[ctl.set_lane] <= 1'b1;
			end
			if (sts.hit) begin
				ready_q[first] <= 1'b0;
			end
			if (ctl.cfg_we) begin
				mask_q <= ctl.cfg_bits;
			end
			tok_q.vld     <= tok_in.vld && !sts.hit && !sts.miss_end;
			tok_q.wrapped <= tok_in.wrapped;
		end
	end

	`MBX_ASSERT_NOW(a_hit_not_miss, sts.hit, !sts.miss_end, "cell hit and miss together")
	`MBX_ASSERT_NEXT(a_hit_stops_tok, sts.hit, !tok_out.vld, "token passed on after a hit")
	`MBX_ASSERT_NEXT(a_hit_clears, sts.hit, !ready_q[$past(sts.hit_lane)], "served slot not cleared")

endmodule

FILE: rtl/multi_sender_mailbox_round_robin.sv
// A send passes from the request transfer through S_SEND and S_OUT; a receive passes
// through S_START and S_SCAN, where the search token hops one cell of the ring of CELLS =
// ceil(SLOT_COUNT/8) cells per cycle, then S_OUT, which waits for a free output register.
// A request is taken only in S_IDLE; a response waiting in the output register does not block
// the next request transfer. Reset (arst_n, asynchronous) empties all slots, registers
// sender 0 only and sets the last-served slot to 0; stored message words are not cleared.
`include "multi_sender_mailbox_round_robin_defines.svh"

module multi_sender_mailbox_round_robin import mbx_pkg::*; #(
	parameter int SLOT_COUNT   = 64,
	parameter int MESSAGE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	mbx_req_if.sink   req,
	mbx_rsp_if.source rsp,
	mbx_cfg_if.sink   cfg
);

	localparam int CELLS    = (SLOT_COUNT + LANES - 1) / LANES;
	localparam int CELL_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int GIDX_W   = $clog2(CELLS * LANES);
	localparam int SIDX_W   = $clog2(SLOT_COUNT);
	localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
	localparam int COPY_W   = (MESSAGE_BITS < PAYLOAD_W) ? MESSAGE_BITS : PAYLOAD_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEND,
		S_START,
		S_SCAN,
		S_OUT
	} state_t;

	state_t               state_q;
	logic [SENDER_W-1:0]  sender_q;
	logic [MSG_W-1:0]     message_q;
	status_t              res_status_q;
	logic [SENDER_W-1:0]  res_slot_q;
	logic                 out_vld_q;
	status_t              out_status_q;
	logic [SENDER_W-1:0]  out_slot_q;
	logic [PAYLOAD_W-1:0] out_payload_q;
	logic [SIDX_W-1:0]    last_served_q;
	logic                 cfg_pend_q;

	logic [MESSAGE_BITS-1:0] mem [SLOT_COUNT];
	logic [MESSAGE_BITS-1:0] rdata_q;

	cell_ctl_t ctl [CELLS];
	cell_sts_t sts [CELLS];
	tok_t      tok_in [CELLS];
	tok_t      tok_out [CELLS];
	logic [CELLS-1:0] tok_vld;

	logic [CELLS*LANES-1:0] mask_pad;
	logic [SIDX_W-1:0]      start;
	logic [GIDX_W-1:0]      start_pad;
	logic [CELL_W-1:0]      start_cell;
	logic [LANE_W-1:0]      start_lo;
	logic                   inject;
	logic                   hit_any;
	logic                   miss_any;
	logic [GIDX_W-1:0]      hit_g;
	logic [SIDX_W-1:0]      hit_idx;
	logic [CNT_W-1:0]       ones_sum;
	logic [SIDX_W-1:0]      cfg_last;
	logic                   in_range;
	logic [CELL_W-1:0]      snd_cell;
	logic [LANE_W-1:0]      snd_lane;
	logic                   reg_ok;
	logic                   busy;
	logic                   snd_take;
	logic [MESSAGE_BITS-1:0] wdata;
	logic [PAYLOAD_W-1:0]   pay;
	logic                   out_free;

	assign req.ready   = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;
	assign rsp.valid   = out_vld_q;
	assign rsp.status  = out_status_q;
	assign rsp.slot    = out_slot_q;
	assign rsp.payload = out_payload_q;
	assign out_free    = !out_vld_q || rsp.ready;

	// round-robin start point and the cell that holds it
	always_comb begin
		start      = (last_served_q == SIDX_W'(SLOT_COUNT - 1)) ? '0 : last_served_q + 1'b1;
		start_pad  = GIDX_W'(start);
		start_cell = CELL_W'(start_pad >> LANE_W);
		start_lo   = start_pad[LANE_W-1:0];
		inject     = (state_q == S_START);
	end

	// registration bits beyond the slot count are dropped
	always_comb begin
		mask_pad = '0;
		mask_pad[SLOT_COUNT-1:0] = cfg.sender_mask[SLOT_COUNT-1:0];
	end

	// send checks against the sender's cell
	always_comb begin
		in_range = ({1'b0, sender_q} < (SENDER_W + 1)'(SLOT_COUNT));
		snd_cell = CELL_W'(sender_q >> LANE_W);
		snd_lane = sender_q[LANE_W-1:0];
		reg_ok   = in_range && sts[snd_cell].mask[snd_lane];
		busy     = sts[snd_cell].ready[snd_lane];
		snd_take = (state_q == S_SEND) && reg_ok && !busy;
	end

	// ring of cells
	for (genvar c = 0; c < CELLS; c++) begin : g_cell
		localparam int PREV = (c == 0) ? CELLS - 1 : c - 1;

		always_comb begin
			ctl[c].set_vld  = snd_take && (snd_cell == CELL_W'(c));
			ctl[c].set_lane = snd_lane;
			ctl[c].cfg_we   = cfg.valid;
			ctl[c].cfg_bits = mask_pad[c*LANES +: LANES];
			ctl[c].is_start = (start_cell == CELL_W'(c));
			ctl[c].start_lo = start_lo;
			if (inject && ctl[c].is_start) begin
				tok_in[c].vld     = 1'b1;
				tok_in[c].wrapped = 1'b0;
			end else begin
				tok_in[c].vld     = tok_out[PREV].vld;
				tok_in[c].wrapped = tok_out[PREV].wrapped || (c == 0);
			end
		end

		assign tok_vld[c] = tok_out[c].vld;

		mbx_cell #(
			.MASK_RST((c == 0) ? LANES'(1) : LANES'(0))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[c]),
			.tok_in  (tok_in[c]),
			.tok_out (tok_out[c]),
			.sts     (sts[c])
		);
	end

	// combine cell answers: served slot, end of search, registered count
	always_comb begin
		hit_any  = 1'b0;
		miss_any = 1'b0;
		hit_g    = '0;
		ones_sum = '0;
		for (int c = 0; c < CELLS; c++) begin
			hit_any  = hit_any || sts[c].hit;
			miss_any = miss_any || sts[c].miss_end;
			if (sts[c].hit) begin
				hit_g = hit_g | GIDX_W'(c * LANES) | GIDX_W'(sts[c].hit_lane);
			end
			ones_sum = ones_sum + CNT_W'(sts[c].ones);
		end
		hit_idx  = hit_g[SIDX_W-1:0];
		cfg_last = (ones_sum == '0) ? SIDX_W'(SLOT_COUNT - 1) : SIDX_W'(ones_sum - 1'b1);
	end

	// message width adaption on write and read
	always_comb begin
		wdata = '0;
		wdata[COPY_W-1:0] = message_q[COPY_W-1:0];
		pay = '0;
		pay[COPY_W-1:0] = rdata_q[COPY_W-1:0];
	end

	// message store
	always_ff @(posedge clk) begin
		if (snd_take) begin
			mem[sender_q[SIDX_W-1:0]] <= wdata;
		end
		if (hit_any) begin
			rdata_q <= mem[hit_idx];
		end
	end

	// control sequencer with result and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			sender_q      <= '0;
			message_q     <= '0;
			res_status_q  <= ST_ACCEPTED;
			res_slot_q    <= '0;
			out_vld_q     <= 1'b0;
			out_status_q  <= ST_ACCEPTED;
			out_slot_q    <= '0;
			out_payload_q <= '0;
			last_served_q <= '0;
			cfg_pend_q    <= 1'b0;
		end else begin
			cfg_pend_q <= cfg.valid;
			if (cfg_pend_q && !hit_any) begin
				last_served_q <= cfg_last;
			end
			// the output stage reloads the register itself
			if (rsp.ready && state_q != S_OUT) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						sender_q  <= req.sender;
						message_q <= req.message;
						state_q   <= req.kind ? S_START : S_SEND;
					end
				end
				S_SEND: begin
					res_slot_q <= sender_q;
					if (!reg_ok) begin
						res_status_q <= ST_UNREGISTERED;
					end else if (busy) begin
						res_status_q <= ST_BUSY;
					end else begin
						res_status_q <= ST_ACCEPTED;
					end
					state_q <= S_OUT;
				end
				S_START, S_SCAN: begin
					if (hit_any) begin
						res_status_q  <= ST_DELIVERED;
						res_slot_q    <= SENDER_W'(hit_idx);
						last_served_q <= hit_idx;
						state_q       <= S_OUT;
					end else if (miss_any) begin
						res_status_q <= ST_EMPTY;
						res_slot_q   <= '0;
						state_q      <= S_OUT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_vld_q     <= 1'b1;
						out_status_q  <= res_status_q;
						out_slot_q    <= res_slot_q;
						out_payload_q <= (res_status_q == ST_DELIVERED) ? pay : '0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`MBX_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vld), "more than one search token in the ring")
	`MBX_ASSERT_NOW(a_idle_no_token, state_q == S_IDLE, tok_vld == '0, "token alive while idle")
	`MBX_ASSERT_NEXT(a_last_served, hit_any, last_served_q == $past(hit_idx), "last served not updated")

endmodule

FILE: tb/multi_sender_mailbox_round_robin_tb.sv
// self-checking bench for the round-robin mailbox: directed cases, then random phases
// depends on mbx_pkg, the mbx_req_if / mbx_rsp_if / mbx_cfg_if interfaces and the rtl top
module multi_sender_mailbox_round_robin_tb;
	import mbx_pkg::*;

	localparam int SLOTS          = 64;
	localparam int SETTLE_CYCLES  = 12;   // ring of 8 cells plus the output stages
	localparam int ITEMS_PER_PHASE = 166;
	localparam int STALL_LIMIT    = 3000;

	localparam bit KIND_SEND = 1'b0;
	localparam bit KIND_RECV = 1'b1;

	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SRC_IDLE,
		PACE_SINK_STALL,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		status_t              status;
		logic [SENDER_W-1:0]  slot;
		logic [PAYLOAD_W-1:0] payload;
	} mail_result_t;

	// mailbox state mirror and queue of results still owed by the block
	class mailbox_scoreboard;
		logic [MASK_W-1:0]    enrolled_mask;
		bit                   slot_full [SLOTS];
		logic [MSG_W-1:0]     slot_word [SLOTS];
		int unsigned          last_slot;
		mail_result_t         owed [$];
		int                   errors;

		function void clear();
			enrolled_mask = 64'd1;
			foreach (slot_full[i]) slot_full[i] = 1'b0;
			last_slot = 0;
			owed.delete();
			errors = 0;
		endfunction

		function void write_mask(logic [MASK_W-1:0] m);
			int unsigned n;
			enrolled_mask = m;
			n = $countones(m);
			last_slot = (n == 0) ? SLOTS - 1 : n - 1;
		endfunction

		// work out the result of one accepted request
		function void note_request(bit kind, logic [SENDER_W-1:0] sender,
				logic [MSG_W-1:0] word);
			mail_result_t r;
			int unsigned s;
			r.slot    = sender;
			r.payload = '0;
			if (kind == KIND_SEND) begin
				if (!enrolled_mask[sender]) begin
					r.status = ST_UNREGISTERED;
				end else if (slot_full[sender]) begin
					r.status = ST_BUSY;
				end else begin
					slot_word[sender] = word;
					slot_full[sender] = 1'b1;
					r.status = ST_ACCEPTED;
				end
			end else begin
				r.status = ST_EMPTY;
				r.slot   = '0;
				s = last_slot;
				for (int k = 0; k < SLOTS; k++) begin
					s = (s + 1) % SLOTS;
					if (slot_full[s]) begin
						slot_full[s] = 1'b0;
						last_slot = s;
						r.status  = ST_DELIVERED;
						r.slot    = s[SENDER_W-1:0];
						r.payload = slot_word[s];
						break;
					end
				end
			end
			owed.push_back(r);
		endfunction

		function int pending();
			return owed.size();
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_result(status_t status, logic [SENDER_W-1:0] slot,
				logic [PAYLOAD_W-1:0] payload);
			mail_result_t r;
			if (owed.size() == 0) begin
				report($sformatf("unexpected result status %0d slot %0d", status, slot));
			end else begin
				r = owed.pop_front();
				if (status !== r.status)
					report($sformatf("status %0d, expected %0d", status, r.status));
				if (slot !== r.slot)
					report($sformatf("slot %0d, expected %0d", slot, r.slot));
				if (payload !== r.payload)
					report($sformatf("payload %h, expected %h", payload, r.payload));
			end
		endtask
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	pace_t pace = PACE_FULL;
	int    idle_cycles = 0;
	int unsigned enrolled [$];
	mailbox_scoreboard book = new();

	logic [MASK_W-1:0] phase_masks [8] = '{
		64'hFFFF_FFFF_FFFF_FFFF,
		64'h0000_0000_0000_0000,
		64'hAAAA_AAAA_AAAA_AAAA,
		64'h8000_0000_0000_0001,
		64'h0000_0000_FFFF_0000,
		64'h5555_5555_5555_5555,
		64'h0000_0000_0000_0001,
		64'hFFFF_FFFF_FFFF_FFFF
	};

	mbx_req_if req_ch ();
	mbx_rsp_if rsp_ch ();
	mbx_cfg_if cfg_ch ();

	multi_sender_mailbox_round_robin DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stalls, changed at the falling edge
	always @(negedge clk) begin
		case (pace)
			PACE_SINK_STALL: rsp_ch.ready <= ($urandom_range(99) >= 52);
			PACE_BOTH:       rsp_ch.ready <= ($urandom_range(99) >= 14);
			default:         rsp_ch.ready <= 1'b1;
		endcase
	end

	// result transfers
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			book.check_result(rsp_ch.status, rsp_ch.slot, rsp_ch.payload);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function bit sender_waits();
		case (pace)
			PACE_SRC_IDLE: return $urandom_range(99) < 52;
			PACE_BOTH:     return $urandom_range(99) < 14;
			default:       return 1'b0;
		endcase
	endfunction

	// one request transfer; called and returns at a falling edge
	task automatic push_request(input bit kind, input logic [SENDER_W-1:0] sender,
			input logic [MSG_W-1:0] word);
		while (sender_waits()) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.kind    <= kind;
		req_ch.sender  <= sender;
		req_ch.message <= word;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		book.note_request(kind, sender, word);
		@(negedge clk);
	endtask

	// mask write once the block has drained
	task automatic write_sender_mask(input logic [MASK_W-1:0] m);
		req_ch.valid <= 1'b0;
		while (book.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.sender_mask <= m;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		book.write_mask(m);
		enrolled.delete();
		for (int i = 0; i < SLOTS; i++)
			if (m[i]) enrolled.push_back(i);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// mostly sends from registered senders and receives, some stray senders
	task automatic random_item();
		bit                  kind;
		logic [SENDER_W-1:0] sender;
		logic [MSG_W-1:0]    word;
		kind = ($urandom_range(99) < 42) ? KIND_RECV : KIND_SEND;
		if (enrolled.size() != 0 && $urandom_range(99) < 85)
			sender = SENDER_W'(enrolled[$urandom_range(enrolled.size() - 1)]);
		else
			sender = SENDER_W'($urandom_range(SLOTS - 1));
		case ($urandom_range(9))
			0:       word = '0;
			1:       word = '1;
			default: word = $urandom;
		endcase
		push_request(kind, sender, word);
	endtask

	initial begin
		req_ch.valid       = 1'b0;
		req_ch.kind        = KIND_SEND;
		req_ch.sender      = '0;
		req_ch.message     = '0;
		rsp_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.sender_mask = '0;
		book.clear();
		enrolled.push_back(0);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset mask: only sender 0 registered
		push_request(KIND_SEND, 6'd0, 32'hFFFF_FFFF);
		push_request(KIND_SEND, 6'd0, 32'h0000_0000);
		push_request(KIND_SEND, 6'd1, 32'h1111_1111);
		push_request(KIND_SEND, 6'd63, 32'h2222_2222);
		push_request(KIND_RECV, 6'd0, 32'h0);
		push_request(KIND_RECV, 6'd0, 32'h0);

		// all registered: search starts after slot 63, so slot 0 comes first
		write_sender_mask('1);
		push_request(KIND_SEND, 6'd63, 32'h0000_0000);
		push_request(KIND_SEND, 6'd0, 32'hA5A5_A5A5);
		push_request(KIND_SEND, 6'd32, 32'h1234_5678);
		push_request(KIND_RECV, 6'd63, 32'hFFFF_FFFF);
		push_request(KIND_RECV, 6'd0, 32'h0);
		push_request(KIND_RECV, 6'd0, 32'h0);
		push_request(KIND_RECV, 6'd0, 32'h0);
		push_request(KIND_SEND, 6'd5, 32'h5A5A_5A5A);
		push_request(KIND_SEND, 6'd42, 32'h8000_0001);

		// sender deregistered while its slot is full, then empty mask refusals
		write_sender_mask('0);
		push_request(KIND_SEND, 6'd5, 32'hDEAD_BEEF);
		push_request(KIND_SEND, 6'd0, 32'h0);
		push_request(KIND_RECV, 6'd0, 32'h0);
		push_request(KIND_RECV, 6'd0, 32'h0);
		push_request(KIND_RECV, 6'd0, 32'h0);

		// random phases, one pacing pattern per phase
		for (int p = 0; p < 8; p++) begin
			write_sender_mask((p == 6) ? {$urandom, $urandom} : phase_masks[p]);
			pace = pace_t'(p % 4);
			repeat (ITEMS_PER_PHASE) random_item();
		end

		req_ch.valid <= 1'b0;
		while (book.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.pending() != 0)
			book.report($sformatf("%0d results never arrived", book.pending()));
		if (book.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

FILE: sim.f
+incdir+rtl
rtl/mbx_pkg.sv
rtl/mbx_if.sv
rtl/mbx_cell.sv
rtl/multi_sender_mailbox_round_robin.sv
tb/multi_sender_mailbox_round_robin_tb.sv
